// ===== design/bfr_pkg.sv =====
`timescale 1ns / 1ps

package bfr_pkg;

    // Font geometry.
    localparam int FONT_WIDTH      = 8;
    localparam int FONT_HEIGHT     = 16;
    localparam int MAX_GLYPHS      = 256;
    localparam int BYTES_PER_PIXEL = 4;
    localparam int PIXELS_PER_ROW  = 8;

    // Field widths.
    localparam int ACTION_W    = 2;
    localparam int FONT_ADDR_W = 12;
    localparam int FONT_BYTE_W = 8;
    localparam int CURSOR_W    = 8;
    localparam int CODE_W      = 8;
    localparam int ADDR_W      = 32;
    localparam int PITCH_W     = 16;
    localparam int COLOR_W     = 24;
    localparam int GCOUNT_W    = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Derived widths.
    localparam int ROW_W      = (FONT_HEIGHT > 1) ? $clog2(FONT_HEIGHT) : 1;
    localparam int GLYPH_W    = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int LINE_SCL_W = CURSOR_W + ROW_W;
    localparam int PROD_W     = LINE_SCL_W + PITCH_W;
    localparam int CELL_BYTES = FONT_WIDTH * BYTES_PER_PIXEL;

    // Actions.
    localparam logic [ACTION_W-1:0] ACT_LOAD_FONT  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET_CURSOR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DRAW_CHAR  = 2'd2;

    // Special character codes.
    localparam logic [CODE_W-1:0] CHAR_CR   = 8'd13;
    localparam logic [CODE_W-1:0] CHAR_LF   = 8'd10;
    localparam logic [CODE_W-1:0] CHAR_SKIP = 8'd255;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPAQUE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_CNT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_255   = 3'd6;

    // Configuration reset values.
    localparam logic [ADDR_W-1:0]   RST_FRAME_BASE = '0;
    localparam logic [PITCH_W-1:0]  RST_ROW_PITCH  = 16'd4096;
    localparam logic [COLOR_W-1:0]  RST_FG_COLOR   = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0]  RST_BG_COLOR   = '0;
    localparam logic                RST_OPAQUE     = 1'b1;
    localparam logic [GCOUNT_W-1:0] RST_GLYPH_CNT  = 9'd256;
    localparam logic                RST_SKIP_255   = 1'b1;

    // Control from the sequencer to the address unit.
    typedef struct packed {
        logic load;
        logic add_prod;
        logic step;
    } addr_ctl_t;

endpackage

// ===== design/bfr_if.sv =====
`timescale 1ns / 1ps

// Input item channel.
interface bfr_in_if;
    logic                               valid;
    logic                               ready;
    logic [bfr_pkg::ACTION_W-1:0]       action;
    logic [bfr_pkg::FONT_ADDR_W-1:0]    font_addr;
    logic [bfr_pkg::FONT_BYTE_W-1:0]    font_byte;
    logic [bfr_pkg::CURSOR_W-1:0]       cursor_col;
    logic [bfr_pkg::CURSOR_W-1:0]       cursor_row;
    logic [bfr_pkg::CODE_W-1:0]         char_code;

    modport source (output valid, action, font_addr, font_byte, cursor_col, cursor_row,
                    char_code, input ready);
    modport sink (input valid, action, font_addr, font_byte, cursor_col, cursor_row,
                  char_code, output ready);
endinterface

// Result channel, one transaction per glyph row.
interface bfr_out_if;
    logic                           valid;
    logic                           ready;
    logic [bfr_pkg::ADDR_W-1:0]     row_address;
    logic [7:0]                     write_mask;
    logic [bfr_pkg::COLOR_W-1:0]    pixel0;
    logic [bfr_pkg::COLOR_W-1:0]    pixel1;
    logic [bfr_pkg::COLOR_W-1:0]    pixel2;
    logic [bfr_pkg::COLOR_W-1:0]    pixel3;
    logic [bfr_pkg::COLOR_W-1:0]    pixel4;
    logic [bfr_pkg::COLOR_W-1:0]    pixel5;
    logic [bfr_pkg::COLOR_W-1:0]    pixel6;
    logic [bfr_pkg::COLOR_W-1:0]    pixel7;
    logic                           last_row;

    modport source (output valid, row_address, write_mask, pixel0, pixel1, pixel2, pixel3,
                    pixel4, pixel5, pixel6, pixel7, last_row, input ready);
    modport sink (input valid, row_address, write_mask, pixel0, pixel1, pixel2, pixel3,
                  pixel4, pixel5, pixel6, pixel7, last_row, output ready);
endinterface

// Configuration write channel.
interface bfr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bfr_pkg::CFG_IDX_W-1:0]      index;
    logic [bfr_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/bfr_glyph_ram.sv =====
`timescale 1ns / 1ps

module bfr_glyph_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 8
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/bfr_addr_unit.sv =====
`timescale 1ns / 1ps

module bfr_addr_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bfr_pkg::addr_ctl_t              ctl,
    input  logic [bfr_pkg::ADDR_W-1:0]      frame_base,
    input  logic [bfr_pkg::PITCH_W-1:0]     row_pitch,
    input  logic [bfr_pkg::CURSOR_W-1:0]    col_pos,
    input  logic [bfr_pkg::CURSOR_W-1:0]    line_pos,
    output logic [bfr_pkg::ADDR_W-1:0]      row_addr
);

    logic [bfr_pkg::ADDR_W-1:0]     acc_reg;
    logic [bfr_pkg::ADDR_W-1:0]     acc_next;
    logic [bfr_pkg::PROD_W-1:0]     prod_reg;
    logic [bfr_pkg::PROD_W-1:0]     prod_next;
    logic [bfr_pkg::LINE_SCL_W-1:0] line_scaled;
    logic [bfr_pkg::ADDR_W-1:0]     op_a;
    logic [bfr_pkg::ADDR_W-1:0]     op_b;
    logic [bfr_pkg::ADDR_W-1:0]     sum;

    // Pixel-row offset of the text line: line * FONT_HEIGHT * pitch.
    assign line_scaled = bfr_pkg::LINE_SCL_W'(line_pos)
                       * bfr_pkg::LINE_SCL_W'(bfr_pkg::FONT_HEIGHT);
    assign prod_next   = bfr_pkg::PROD_W'(line_scaled) * bfr_pkg::PROD_W'(row_pitch);

    // Shared adder operand selection: base plus column, then line offset, then pitch steps.
    always_comb
    begin
        if (ctl.load)
        begin
            op_a = frame_base;
            op_b = bfr_pkg::ADDR_W'(col_pos) * bfr_pkg::ADDR_W'(bfr_pkg::CELL_BYTES);
        end
        else if (ctl.add_prod)
        begin
            op_a = acc_reg;
            op_b = bfr_pkg::ADDR_W'(prod_reg);
        end
        else
        begin
            op_a = acc_reg;
            op_b = bfr_pkg::ADDR_W'(row_pitch);
        end
    end

    assign sum = op_a + op_b;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.load || ctl.add_prod || ctl.step)
        begin
            acc_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // The product is captured together with the first addition.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign row_addr = acc_reg;

endmodule

// ===== design/bitmap_font_text_renderer.sv =====
`timescale 1ns / 1ps
// A drawn character goes through the address setup states S_LOAD and S_ADD, then each glyph row
// through the read stage and the output register. It holds the input off for two address setup
// steps through the shared adder, then one glyph store read per row; other items keep it ready.
// Rows leave at one per cycle unless the result channel stalls.
// Reset: cursor and control clear, configuration takes its defaults, glyph store is undefined.

module bitmap_font_text_renderer (
    input  logic        clk,
    input  logic        rst_n,
    bfr_in_if.sink      item,
    bfr_out_if.source   result,
    bfr_cfg_if.sink     cfg
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_ADD  = 4'b0100,
        S_ROWS = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    logic [bfr_pkg::ADDR_W-1:0]   frame_base_reg;
    logic [bfr_pkg::PITCH_W-1:0]  row_pitch_reg;
    logic [bfr_pkg::COLOR_W-1:0]  fg_color_reg;
    logic [bfr_pkg::COLOR_W-1:0]  bg_color_reg;
    logic                         opaque_reg;
    logic [bfr_pkg::GCOUNT_W-1:0] glyph_count_reg;
    logic                         skip_255_reg;

    // Cursor and per-character state.
    logic [bfr_pkg::CURSOR_W-1:0] col_pos_reg;
    logic [bfr_pkg::CURSOR_W-1:0] col_pos_next;
    logic [bfr_pkg::CURSOR_W-1:0] line_pos_reg;
    logic [bfr_pkg::CURSOR_W-1:0] line_pos_next;
    logic [bfr_pkg::GLYPH_W-1:0]  glyph_reg;
    logic [bfr_pkg::GLYPH_W-1:0]  glyph_next;
    logic [bfr_pkg::ROW_W-1:0]    row_reg;
    logic [bfr_pkg::ROW_W-1:0]    row_next;

    logic                         item_acc;
    logic                         glyph_ok;
    logic                         is_last;
    logic                         issue;
    bfr_pkg::addr_ctl_t           actl;
    logic [bfr_pkg::ADDR_W-1:0]   cur_addr;

    // Glyph store ports.
    logic                            ram_we;
    logic [bfr_pkg::FONT_ADDR_W-1:0] ram_raddr;
    logic [bfr_pkg::FONT_BYTE_W-1:0] ram_rdata;

    // Read stage, aligned with the glyph store read data.
    logic                         b_valid_reg;
    logic                         b_valid_next;
    logic [bfr_pkg::ADDR_W-1:0]   b_addr_reg;
    logic                         b_last_reg;
    logic                         b_adv;

    // Output register.
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_load;
    logic [bfr_pkg::ADDR_W-1:0]   out_addr_reg;
    logic [7:0]                   out_mask_reg;
    logic [7:0]                   mask_calc;
    logic [bfr_pkg::COLOR_W-1:0]  out_pix_reg [bfr_pkg::PIXELS_PER_ROW];
    logic [bfr_pkg::COLOR_W-1:0]  pix_calc [bfr_pkg::PIXELS_PER_ROW];
    logic                         out_last_reg;

    assign item.ready = (state_reg == S_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg  <= bfr_pkg::RST_FRAME_BASE;
            row_pitch_reg   <= bfr_pkg::RST_ROW_PITCH;
            fg_color_reg    <= bfr_pkg::RST_FG_COLOR;
            bg_color_reg    <= bfr_pkg::RST_BG_COLOR;
            opaque_reg      <= bfr_pkg::RST_OPAQUE;
            glyph_count_reg <= bfr_pkg::RST_GLYPH_CNT;
            skip_255_reg    <= bfr_pkg::RST_SKIP_255;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                bfr_pkg::CFG_FRAME_BASE: frame_base_reg  <= cfg.data[bfr_pkg::ADDR_W-1:0];
                bfr_pkg::CFG_ROW_PITCH:  row_pitch_reg   <= cfg.data[bfr_pkg::PITCH_W-1:0];
                bfr_pkg::CFG_FG_COLOR:   fg_color_reg    <= cfg.data[bfr_pkg::COLOR_W-1:0];
                bfr_pkg::CFG_BG_COLOR:   bg_color_reg    <= cfg.data[bfr_pkg::COLOR_W-1:0];
                bfr_pkg::CFG_OPAQUE:     opaque_reg      <= cfg.data[0];
                bfr_pkg::CFG_GLYPH_CNT:  glyph_count_reg <= cfg.data[bfr_pkg::GCOUNT_W-1:0];
                bfr_pkg::CFG_SKIP_255:   skip_255_reg    <= cfg.data[0];
                default:                 ;
            endcase
        end
    end

    // Codes beyond the font fall back to glyph 0.
    assign glyph_ok = ({1'b0, item.char_code} < glyph_count_reg)
                   && (int'(item.char_code) < bfr_pkg::MAX_GLYPHS);
    assign is_last  = (row_reg == bfr_pkg::ROW_W'(bfr_pkg::FONT_HEIGHT - 1));
    assign issue    = (state_reg == S_ROWS) && b_adv;

    // Sequencer: cursor actions, address setup and one row read per cycle when not stalled.
    always_comb
    begin
        state_next    = state_reg;
        col_pos_next  = col_pos_reg;
        line_pos_next = line_pos_reg;
        glyph_next    = glyph_reg;
        row_next      = row_reg;
        ram_we        = 1'b0;
        actl          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    case (item.action)
                        bfr_pkg::ACT_LOAD_FONT:
                        begin
                            ram_we = 1'b1;
                        end
                        bfr_pkg::ACT_SET_CURSOR:
                        begin
                            col_pos_next  = item.cursor_col;
                            line_pos_next = item.cursor_row;
                        end
                        bfr_pkg::ACT_DRAW_CHAR:
                        begin
                            if (item.char_code == bfr_pkg::CHAR_CR)
                            begin
                                col_pos_next = '0;
                            end
                            else if (item.char_code == bfr_pkg::CHAR_LF)
                            begin
                                col_pos_next  = '0;
                                line_pos_next = line_pos_reg + 1'b1;
                            end
                            else if (!(item.char_code == bfr_pkg::CHAR_SKIP && skip_255_reg))
                            begin
                                glyph_next = glyph_ok ? bfr_pkg::GLYPH_W'(item.char_code) : '0;
                                row_next   = '0;
                                state_next = S_LOAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD:
            begin
                actl.load  = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                actl.add_prod = 1'b1;
                state_next    = S_ROWS;
            end
            S_ROWS:
            begin
                if (issue)
                begin
                    actl.step = 1'b1;
                    row_next  = row_reg + 1'b1;
                    if (is_last)
                    begin
                        col_pos_next = col_pos_reg + 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            col_pos_reg  <= '0;
            line_pos_reg <= '0;
            glyph_reg    <= '0;
            row_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            col_pos_reg  <= col_pos_next;
            line_pos_reg <= line_pos_next;
            glyph_reg    <= glyph_next;
            row_reg      <= row_next;
        end
    end

    // Shared address adder and line-offset multiplier.
    bfr_addr_unit u_addr (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (actl),
        .frame_base (frame_base_reg),
        .row_pitch  (row_pitch_reg),
        .col_pos    (col_pos_reg),
        .line_pos   (line_pos_reg),
        .row_addr   (cur_addr)
    );

    // Glyph store address is glyph * FONT_HEIGHT + row.
    assign ram_raddr = bfr_pkg::FONT_ADDR_W'(int'(glyph_reg) * bfr_pkg::FONT_HEIGHT
                                             + int'(row_reg));

    bfr_glyph_ram #(
        .ADDR_BITS (bfr_pkg::FONT_ADDR_W),
        .DATA_BITS (bfr_pkg::FONT_BYTE_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (item.font_addr),
        .wr_data (item.font_byte),
        .rd_en   (issue),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Read stage and output register handshake.
    assign out_load       = b_valid_reg && (!out_valid_reg || result.ready);
    assign b_adv          = !b_valid_reg || out_load;
    assign b_valid_next   = issue ? 1'b1 : (out_load ? 1'b0 : b_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_addr_reg <= cur_addr;
            b_last_reg <= is_last;
        end
    end

    // Pixel colors and write mask from the glyph row bits; the MSB side is leftmost.
    always_comb
    begin
        mask_calc = '0;
        for (int i = 0; i < bfr_pkg::PIXELS_PER_ROW; i++)
        begin
            pix_calc[i] = '0;
            if (i < bfr_pkg::FONT_WIDTH)
            begin
                if (ram_rdata[bfr_pkg::FONT_WIDTH - 1 - i])
                begin
                    pix_calc[i]  = fg_color_reg;
                    mask_calc[i] = 1'b1;
                end
                else if (opaque_reg)
                begin
                    pix_calc[i]  = bg_color_reg;
                    mask_calc[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_addr_reg <= b_addr_reg;
            out_mask_reg <= mask_calc;
            out_pix_reg  <= pix_calc;
            out_last_reg <= b_last_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.row_address = out_addr_reg;
    assign result.write_mask  = out_mask_reg;
    assign result.pixel0      = out_pix_reg[0];
    assign result.pixel1      = out_pix_reg[1];
    assign result.pixel2      = out_pix_reg[2];
    assign result.pixel3      = out_pix_reg[3];
    assign result.pixel4      = out_pix_reg[4];
    assign result.pixel5      = out_pix_reg[5];
    assign result.pixel6      = out_pix_reg[6];
    assign result.pixel7      = out_pix_reg[7];
    assign result.last_row    = out_last_reg;

endmodule
